// ----- rtl/pst_pkg.sv -----
// Package for the peer set table: capacity, widths, command and status codes,
// the entry and memory request types, and the controller state type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pst_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = 5;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;
    localparam int IP_W     = 32;
    localparam int PORT_W   = 16;

    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_LIST   = 2'd2
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_MISS  = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_SHIFT,
        S_LIST,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic [IP_W-1:0]   ip;
        logic [PORT_W-1:0] port;
    } t_entry;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        t_entry           wdata;
        logic             re;
        logic [IDX_W-1:0] raddr;
    } t_ram_req;

endpackage

`default_nettype wire

// ----- rtl/pst_if.sv -----
// Channel interfaces of the peer set table: the command channel and the
// result channel, each with valid, ready and payload. Uses pst_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface pst_in_if;
    logic                           valid;
    logic                           ready;
    logic [pst_pkg::CMD_W-1:0]      command;
    logic [pst_pkg::IP_W-1:0]       peer_ip;
    logic [pst_pkg::PORT_W-1:0]     peer_port;

    modport source (output valid, command, peer_ip, peer_port, input ready);
    modport sink   (input valid, command, peer_ip, peer_port, output ready);
endinterface

interface pst_out_if;
    logic                           valid;
    logic                           ready;
    logic [pst_pkg::STATUS_W-1:0]   status;
    logic [pst_pkg::IP_W-1:0]       entry_ip;
    logic [pst_pkg::PORT_W-1:0]     entry_port;
    logic [pst_pkg::CNT_W-1:0]      entry_count;
    logic                           last;

    modport source (output valid, status, entry_ip, entry_port, entry_count, last,
                    input ready);
    modport sink   (input valid, status, entry_ip, entry_port, entry_count, last,
                    output ready);
endinterface

`default_nettype wire

// ----- rtl/pst_ram.sv -----
// Entry store of the peer set table: one write port, one read port with
// registered read data that holds while no read is issued. Uses pst_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pst_ram (
    input  wire logic              i_clk,
    input  wire pst_pkg::t_ram_req i_req,
    output pst_pkg::t_entry        o_rdata
);

    pst_pkg::t_entry r_mem [pst_pkg::CAPACITY];
    pst_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- rtl/peer_set_table.sv -----
// Peer set table. An add or a remove walks the stored entries through one memory port,
// and a remove goes on from the match as the entry shift. A list streams one entry per
// cycle while the result side keeps taking them; an empty list answers with the empty
// status. The next command is taken in the cycle after the final result is loaded.
// Synchronous active-low reset empties the table; stored entries are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module peer_set_table (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    pst_in_if.sink     i_in,
    pst_out_if.source  o_out
);

    localparam int IDX_W = pst_pkg::IDX_W;
    localparam int CNT_W = pst_pkg::CNT_W;

    // Controller state. The entry count lives in a register; the entries
    // themselves live in the memory.
    pst_pkg::t_state  r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_idx,   n_idx;     // next entry to read
    logic [IDX_W-1:0] r_pidx,  n_pidx;    // entry whose data is on the read port
    logic             r_pend,  n_pend;    // read data is valid this cycle
    pst_pkg::t_cmd    r_cmd,   n_cmd;
    pst_pkg::t_entry  r_key,   n_key;
    pst_pkg::t_status r_status, n_status;

    // Output register. It lets the table take the next command while a
    // result still waits for its transfer.
    logic                    r_out_valid;
    pst_pkg::t_status        r_out_status;
    logic [pst_pkg::IP_W-1:0]   r_out_ip;
    logic [pst_pkg::PORT_W-1:0] r_out_port;
    logic [CNT_W-1:0]        r_out_count;
    logic                    r_out_last;

    logic                    out_load;
    pst_pkg::t_status        ld_status;
    pst_pkg::t_entry         ld_entry;
    logic                    ld_last;
    logic                    can_emit;
    logic                    hit;
    logic                    list_last;

    pst_pkg::t_ram_req       ram_req;
    pst_pkg::t_entry         ram_rdata;

    pst_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (ram_req),
        .o_rdata (ram_rdata)
    );

    assign can_emit  = !r_out_valid || o_out.ready;
    assign hit       = r_pend && (ram_rdata == r_key);
    assign list_last = ({1'b0, r_pidx} + 1'b1) == r_count;

    // Commands are taken only in the idle state.
    assign i_in.ready = (r_state == pst_pkg::S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pst_pkg::S_IDLE;
            r_count <= '0;
            r_idx   <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_idx   <= n_idx;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pidx   <= n_pidx;
        r_cmd    <= n_cmd;
        r_key    <= n_key;
        r_status <= n_status;
    end

    // The search walks the stored entries with one read issued per cycle and
    // the compare made on the data of the previous read. A remove then shifts
    // every later entry down by reading entry i+1 and writing it to entry i.
    // A list issues the next read in the same cycle that an entry is loaded
    // into the output register, so entries stream at one per cycle while the output register can take them.
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_idx     = r_idx;
        n_pidx    = r_pidx;
        n_pend    = r_pend;
        n_cmd     = r_cmd;
        n_key     = r_key;
        n_status  = r_status;
        out_load  = 1'b0;
        ld_status = pst_pkg::ST_DONE;
        ld_entry  = '0;
        ld_last   = 1'b1;
        ram_req   = '0;

        case (r_state)
            pst_pkg::S_IDLE: begin
                if (i_in.valid) begin
                    n_cmd      = pst_pkg::t_cmd'(i_in.command);
                    n_key.ip   = i_in.peer_ip;
                    n_key.port = i_in.peer_port;
                    n_idx      = '0;
                    n_pend     = 1'b0;
                    case (i_in.command)
                        pst_pkg::CMD_ADD, pst_pkg::CMD_REMOVE: begin
                            n_state = pst_pkg::S_SEARCH;
                        end
                        pst_pkg::CMD_LIST: begin
                            if (r_count == '0) begin
                                n_status = pst_pkg::ST_EMPTY;
                                n_state  = pst_pkg::S_EMIT;
                            end else begin
                                n_state = pst_pkg::S_LIST;
                            end
                        end
                        default: begin
                            // An unknown command changes nothing and has no result.
                        end
                    endcase
                end
            end

            pst_pkg::S_SEARCH: begin
                if (hit) begin
                    n_pend = 1'b0;
                    if (r_cmd == pst_pkg::CMD_ADD) begin
                        n_status = pst_pkg::ST_MISS;
                        n_state  = pst_pkg::S_EMIT;
                    end else begin
                        n_idx   = {1'b0, r_pidx} + 1'b1;
                        n_state = pst_pkg::S_SHIFT;
                    end
                end else if (r_idx == r_count) begin
                    // Every stored entry has been compared without a match.
                    n_pend  = 1'b0;
                    n_state = pst_pkg::S_EMIT;
                    if (r_cmd == pst_pkg::CMD_REMOVE) begin
                        n_status = pst_pkg::ST_MISS;
                    end else if (r_count == pst_pkg::CAP_CNT) begin
                        n_status = pst_pkg::ST_FULL;
                    end else begin
                        ram_req.we    = 1'b1;
                        ram_req.waddr = r_count[IDX_W-1:0];
                        ram_req.wdata = r_key;
                        n_count       = r_count + 1'b1;
                        n_status      = pst_pkg::ST_DONE;
                    end
                end else begin
                    ram_req.re    = 1'b1;
                    ram_req.raddr = r_idx[IDX_W-1:0];
                    n_pidx        = r_idx[IDX_W-1:0];
                    n_idx         = r_idx + 1'b1;
                    n_pend        = 1'b1;
                end
            end

            pst_pkg::S_SHIFT: begin
                if (r_pend) begin
                    ram_req.we    = 1'b1;
                    ram_req.waddr = r_pidx - 1'b1;
                    ram_req.wdata = ram_rdata;
                end
                if (r_idx < r_count) begin
                    ram_req.re    = 1'b1;
                    ram_req.raddr = r_idx[IDX_W-1:0];
                    n_pidx        = r_idx[IDX_W-1:0];
                    n_idx         = r_idx + 1'b1;
                    n_pend        = 1'b1;
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        n_count  = r_count - 1'b1;
                        n_status = pst_pkg::ST_DONE;
                        n_state  = pst_pkg::S_EMIT;
                    end
                end
            end

            pst_pkg::S_LIST: begin
                if (r_pend && can_emit) begin
                    out_load  = 1'b1;
                    ld_status = pst_pkg::ST_DONE;
                    ld_entry  = ram_rdata;
                    ld_last   = list_last;
                end
                if (out_load && list_last) begin
                    n_pend  = 1'b0;
                    n_state = pst_pkg::S_IDLE;
                end else if ((!r_pend || out_load) && (r_idx < r_count)) begin
                    ram_req.re    = 1'b1;
                    ram_req.raddr = r_idx[IDX_W-1:0];
                    n_pidx        = r_idx[IDX_W-1:0];
                    n_idx         = r_idx + 1'b1;
                    n_pend        = 1'b1;
                end else if (out_load) begin
                    n_pend = 1'b0;
                end
            end

            pst_pkg::S_EMIT: begin
                if (can_emit) begin
                    out_load  = 1'b1;
                    ld_status = r_status;
                    ld_last   = 1'b1;
                    n_state   = pst_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = pst_pkg::S_IDLE;
                n_pend  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // The count of an add or remove is already updated when its result
    // leaves the emit state.
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_status <= ld_status;
            r_out_ip     <= ld_entry.ip;
            r_out_port   <= ld_entry.port;
            r_out_count  <= r_count;
            r_out_last   <= ld_last;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.status      = r_out_status;
    assign o_out.entry_ip    = r_out_ip;
    assign o_out.entry_port  = r_out_port;
    assign o_out.entry_count = r_out_count;
    assign o_out.last        = r_out_last;

    // The count never exceeds the table capacity.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= pst_pkg::CAP_CNT)
        else $error("entry count above capacity");

    // The shift never reads and writes the same entry in one cycle.
    a_no_rw_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_req.we && ram_req.re && (ram_req.waddr == ram_req.raddr)))
        else $error("read and write to the same entry in one cycle");

    // The final result of a command returns the controller to idle.
    a_last_ends_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && ld_last) |=> (r_state == pst_pkg::S_IDLE))
        else $error("controller busy after the final result");

    // A result is loaded only into a free or draining output register.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (!r_out_valid || o_out.ready))
        else $error("pending result overwritten");

endmodule

`default_nettype wire

// ----- tb/peer_set_table_tb.sv -----
// Self-checking testbench for the peer set table: add, remove and list traffic
// against a queue-based model of the stored entries. Depends on pst_pkg, pst_if
// and the peer_set_table RTL.
`timescale 1ns / 1ps

module peer_set_table_tb;

    import pst_pkg::*;

    // Command value 3 is not decoded. The block takes the transfer and drops it.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam int CLK_HALF_NS  = 6;
    localparam int RESET_CYCLES = 11;
    localparam int MAX_REPORTS  = 10;
    localparam int MAX_GAP      = 11;
    localparam int HOLD_CYCLES  = 150;
    // Allow for the slowest remove, and a little more, before the end check.
    localparam int TAIL_CYCLES  = 2 * CAPACITY + 8;
    localparam int POOL_SIZE    = 24;
    localparam int SEG_ITEMS    = 35;
    localparam int NUM_SEGS     = 7;
    localparam int HOLD_AT      = 60;
    localparam int DRAIN_AT     = 150;
    // Slowest run: about 285 commands, each with up to 16 results and a random stall
    // before each result, plus the sender gap and the block's own processing. That is
    // about 0.85 ms of simulated time. The limit is roughly six times that.
    localparam int TIMEOUT_NS   = 5_000_000;

    // One result transfer, field for field as it appears on the result channel.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [IP_W-1:0]     ip;
        logic [PORT_W-1:0]   port;
        logic [CNT_W-1:0]    count;
        logic                last;
    } t_pst_result;

    // The scoreboard keeps its own copy of the table as an ordered queue. Each
    // accepted command is applied to that copy, and the results the command
    // should produce are queued. Each result from the block is checked
    // against the oldest queued result.
    class peer_set_scoreboard;
        t_entry      contents[$];
        t_pst_result outstanding[$];
        int          errors;
        int          n_checked;
        int          n_add;
        int          n_remove;
        int          n_list;
        int          n_ignored;
        int          peak;
        int          status_seen[4];

        function int locate(logic [IP_W-1:0] ip, logic [PORT_W-1:0] port);
            foreach (contents[i]) begin
                if (contents[i].ip == ip && contents[i].port == port) return i;
            end
            return -1;
        endfunction

        function void push_result(logic [STATUS_W-1:0] status, logic [IP_W-1:0] ip,
                                  logic [PORT_W-1:0] port, logic last);
            t_pst_result r;
            r.status = status;
            r.ip     = ip;
            r.port   = port;
            r.count  = CNT_W'(contents.size());
            r.last   = last;
            outstanding.push_back(r);
            status_seen[status]++;
        endfunction

        function void note_command(logic [CMD_W-1:0] cmd, logic [IP_W-1:0] ip,
                                   logic [PORT_W-1:0] port);
            int     pos;
            t_entry ent;
            pos = locate(ip, port);
            case (cmd)
                CMD_ADD: begin
                    n_add++;
                    // The duplicate search comes before the full check.
                    if (pos >= 0) begin
                        push_result(ST_MISS, '0, '0, 1'b1);
                    end else if (contents.size() >= CAPACITY) begin
                        push_result(ST_FULL, '0, '0, 1'b1);
                    end else begin
                        ent.ip   = ip;
                        ent.port = port;
                        contents.push_back(ent);
                        push_result(ST_DONE, '0, '0, 1'b1);
                    end
                end
                CMD_REMOVE: begin
                    n_remove++;
                    if (pos < 0) begin
                        push_result(ST_MISS, '0, '0, 1'b1);
                    end else begin
                        contents.delete(pos);
                        push_result(ST_DONE, '0, '0, 1'b1);
                    end
                end
                CMD_LIST: begin
                    n_list++;
                    if (contents.size() == 0) begin
                        push_result(ST_EMPTY, '0, '0, 1'b1);
                    end else begin
                        foreach (contents[i]) begin
                            push_result(ST_DONE, contents[i].ip, contents[i].port,
                                        i == contents.size() - 1);
                        end
                    end
                end
                default: begin
                    n_ignored++;
                end
            endcase
            if (contents.size() > peak) peak = contents.size();
        endfunction

        function void check_result(t_pst_result got);
            t_pst_result want;
            n_checked++;
            if (outstanding.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS) begin
                    $display("%0t: unexpected result status %0d ip %h port %h count %0d last %0b",
                             $time, got.status, got.ip, got.port, got.count, got.last);
                end
                return;
            end
            want = outstanding.pop_front();
            if (got.status !== want.status || got.ip !== want.ip || got.port !== want.port
                    || got.count !== want.count || got.last !== want.last) begin
                errors++;
                if (errors <= MAX_REPORTS) begin
                    $display("%0t: result %0d want status %0d ip %h port %h count %0d last %0b",
                             $time, n_checked, want.status, want.ip, want.port, want.count,
                             want.last);
                    $display("%0t: result %0d got  status %0d ip %h port %h count %0d last %0b",
                             $time, n_checked, got.status, got.ip, got.port, got.count,
                             got.last);
                end
            end
        endfunction

        function int pending();
            return outstanding.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    // When set, both sides run without gaps for the current stretch of traffic.
    bit   no_idle;
    // Raised by the stimulus to make the result side hold off for a long time.
    bit   hold_req;

    t_entry pool[POOL_SIZE];

    peer_set_scoreboard sb;

    pst_in_if  cmd_ch ();
    pst_out_if res_ch ();

    peer_set_table u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (cmd_ch),
        .o_out   (res_ch)
    );

    initial begin
        clk = 1'b0;
        forever #(CLK_HALF_NS) clk = ~clk;
    end

    // Inputs change on the falling edge. Both monitors sample on the rising
    // edge, where every transfer takes place.
    always @(posedge clk) begin
        if (rst_n && cmd_ch.valid && cmd_ch.ready) begin
            sb.note_command(cmd_ch.command, cmd_ch.peer_ip, cmd_ch.peer_port);
        end
    end

    always @(posedge clk) begin
        t_pst_result got;
        if (rst_n && res_ch.valid && res_ch.ready) begin
            got.status = res_ch.status;
            got.ip     = res_ch.entry_ip;
            got.port   = res_ch.entry_port;
            got.count  = res_ch.entry_count;
            got.last   = res_ch.last;
            sb.check_result(got);
        end
    end

    // The result side has its own process. It stalls for a random number of
    // cycles before each transfer. When a hold-off is requested, it keeps
    // ready low for HOLD_CYCLES. The block then fills up and stops taking
    // commands while the sender keeps offering them.
    initial begin : result_sink
        int stall;
        res_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, MAX_GAP);
            if (hold_req) begin
                stall    = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (stall > 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge clk); while (!(res_ch.valid && res_ch.ready));
            @(negedge clk);
        end
    end

    // Offers one command after a random gap and returns on the falling edge
    // after the transfer. Valid is left high. The next call either drops it
    // for a gap or replaces the payload at once, so no edge sees a stale command.
    task automatic send_cmd(input logic [CMD_W-1:0] cmd, input t_entry ent);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_ch.valid     <= 1'b1;
        cmd_ch.command   <= cmd;
        cmd_ch.peer_ip   <= ent.ip;
        cmd_ch.peer_port <= ent.port;
        do @(posedge clk); while (!cmd_ch.ready);
        @(negedge clk);
    endtask

    // Stops offering commands until every queued result has come back.
    task automatic wait_drain();
        cmd_ch.valid <= 1'b0;
        do @(negedge clk); while (sb.pending() > 0);
    endtask

    initial begin : stimulus
        logic [CMD_W-1:0] cmd;
        t_entry           ent;
        int               roll;
        int               add_w;
        int               rem_w;
        int               list_w;
        int               counted;
        int               total;

        sb       = new();
        no_idle  = 1'b0;
        hold_req = 1'b0;

        cmd_ch.valid     = 1'b0;
        cmd_ch.command   = CMD_ADD;
        cmd_ch.peer_ip   = '0;
        cmd_ch.peer_port = '0;
        rst_n            = 1'b0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Working set for the random traffic. Some neighbors share the address
        // and differ only in port, and some share the port and differ only in
        // address. A match must therefore use both fields.
        for (int k = 0; k < POOL_SIZE; k++) begin
            pool[k].ip   = $urandom;
            pool[k].port = PORT_W'($urandom);
            if (k % 4 == 1) begin
                pool[k].ip   = pool[k-1].ip;
                pool[k].port = pool[k-1].port ^ PORT_W'($urandom_range(1, 65535));
            end
            if (k % 4 == 2) begin
                pool[k].port = pool[k-1].port;
                pool[k].ip   = pool[k-1].ip ^ (IP_W'($urandom) | IP_W'(1));
            end
        end

        // Directed part. List an empty table. Add the extreme addresses and
        // ports, including two entries with the same address and different
        // ports. Try a duplicate add, a remove of an absent entry, an
        // undecoded command, and a remove from the middle. Then fill the
        // table, add into the full table, add a duplicate while full, list all
        // sixteen entries, remove the first two entries, and then remove the last entry.
        send_cmd(CMD_LIST,   '0);
        send_cmd(CMD_ADD,    {32'h0000_0000, 16'h0000});
        send_cmd(CMD_ADD,    {32'hFFFF_FFFF, 16'hFFFF});
        send_cmd(CMD_ADD,    {32'hFFFF_FFFF, 16'h0000});
        send_cmd(CMD_ADD,    {32'h0000_0000, 16'h0000});
        send_cmd(CMD_REMOVE, {32'h0000_0000, 16'hFFFF});
        send_cmd(CMD_UNUSED, {32'hFFFF_FFFF, 16'hFFFF});
        send_cmd(CMD_REMOVE, {32'hFFFF_FFFF, 16'hFFFF});
        for (int k = 0; k < CAPACITY - 2; k++) begin
            send_cmd(CMD_ADD, pool[k]);
        end
        send_cmd(CMD_ADD,    pool[POOL_SIZE-1]);
        send_cmd(CMD_ADD,    {32'h0000_0000, 16'h0000});
        send_cmd(CMD_LIST,   '0);
        send_cmd(CMD_REMOVE, {32'h0000_0000, 16'h0000});
        send_cmd(CMD_REMOVE, {32'hFFFF_FFFF, 16'h0000});
        send_cmd(CMD_REMOVE, pool[CAPACITY-3]);

        // Random part, in segments. The segments are weighted toward adds,
        // toward removes, or neither, so the occupancy swings between empty
        // and full. Every fourth segment runs both sides without gaps.
        total = 0;
        for (int seg = 0; seg < NUM_SEGS; seg++) begin
            no_idle = (seg % 4 == 3);
            case (seg % 3)
                0:       begin add_w = 60; rem_w = 20; end
                1:       begin add_w = 20; rem_w = 60; end
                default: begin add_w = 40; rem_w = 40; end
            endcase
            list_w  = 15;
            counted = 0;
            while (counted < SEG_ITEMS) begin
                roll = $urandom_range(0, 99);
                if (roll < add_w) begin
                    cmd = CMD_ADD;
                end else if (roll < add_w + rem_w) begin
                    cmd = CMD_REMOVE;
                end else if (roll < add_w + rem_w + list_w) begin
                    cmd = CMD_LIST;
                end else begin
                    cmd = CMD_UNUSED;
                end
                // Mostly entries from the working set, so adds and removes hit
                // stored entries. A fifth are fully random.
                if ($urandom_range(0, 4) == 0) begin
                    ent.ip   = $urandom;
                    ent.port = PORT_W'($urandom);
                end else begin
                    ent = pool[$urandom_range(0, POOL_SIZE - 1)];
                end
                send_cmd(cmd, ent);
                if (cmd != CMD_UNUSED) counted++;
                total++;
                if (total == HOLD_AT) hold_req = 1'b1;
                if (total == DRAIN_AT) wait_drain();
            end
        end

        wait_drain();
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("Ran %0d adds, %0d removes, %0d lists, %0d undecoded; %0d results checked.",
                 sb.n_add, sb.n_remove, sb.n_list, sb.n_ignored, sb.n_checked);
        $display("Statuses: done %0d, dup/absent %0d, full %0d, empty %0d; peak fill %0d.",
                 sb.status_seen[ST_DONE], sb.status_seen[ST_MISS], sb.status_seen[ST_FULL],
                 sb.status_seen[ST_EMPTY], sb.peak);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("peer_set_table_tb OK");
        end else begin
            $display("peer_set_table_tb NOT OK");
        end
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("Timed out with %0d results still outstanding.", sb.pending());
        $display("peer_set_table_tb NOT OK");
        $finish;
    end

endmodule
